>>> hdl/json_key_string_extractor_top_assert.svh
// Assertion macros for the JSON key string extractor top level.
`ifndef JSON_KEY_STRING_EXTRACTOR_TOP_ASSERT_SVH
`define JSON_KEY_STRING_EXTRACTOR_TOP_ASSERT_SVH

// Same-cycle implication, checked on clk outside reset.
`define JKSE_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define JKSE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/jkse_pkg.sv
// Shared types, constants and defaults of the JSON key string extractor.
package jkse_pkg;

    localparam int KEY_MAX_DEFAULT     = 16;
    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam int KEY_BYTES           = 16;
    localparam int CFG_IDX_W           = 2;
    localparam int CFG_DATA_W          = 64;
    localparam int KEY_LEN_W           = 5;
    localparam int SKIP_W              = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = 2'd2;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [SKIP_W-1:0] UNICODE_DIGITS = 3'd4;

    localparam logic KIND_VALUE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_COLON,
        PH_QUOTE,
        PH_STRING,
        PH_ESCAPE,
        PH_SKIP,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] value_byte;
        logic       found;
        logic       last_of_run;
    } out_item_t;

    typedef struct packed {
        logic      first_valid;
        out_item_t first;
        logic      second_valid;
        out_item_t second;
    } q_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

>>> hdl/jkse_front.sv
// Front end: takes text bytes, matches the quoted key and classifies each byte.
module jkse_front #(
    parameter int KEY_MAX = jkse_pkg::KEY_MAX_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  jkse_pkg::in_item_t                 in_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [jkse_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [jkse_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  jkse_pkg::q_status_t                q_stat,
    output logic                               push,
    output jkse_pkg::q_entry_t                 push_data
);
    import jkse_pkg::*;

    localparam int WIN_LEN = KEY_MAX + 2;
    localparam int SEEN_W  = $clog2(WIN_LEN + 1);
    localparam int LEN_W   = $clog2(KEY_MAX + 1);

    logic [KEY_LEN_W-1:0]  key_length_reg;
    logic [CFG_DATA_W-1:0] key_low_reg;
    logic [CFG_DATA_W-1:0] key_high_reg;

    logic [7:0]        win_reg [WIN_LEN-1];
    logic [7:0]        win_new [WIN_LEN];
    logic [7:0]        key_arr [KEY_BYTES];
    logic [SEEN_W-1:0] seen_reg, seen_step, seen_next;
    logic [SKIP_W-1:0] skip_reg, skip_next, skip_dec;
    phase_t            phase_reg, phase_step, phase_next;

    logic [LEN_W-1:0]  len_c;
    logic [KEY_MAX:0]  len_hit;
    logic              key_hit;
    logic              accept;
    logic [7:0]        c;
    logic              eot;

    function automatic logic [7:0] map_escape(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            8'h62:   r = 8'h08;
            8'h66:   r = 8'h0C;
            8'h6E:   r = 8'h0A;
            8'h72:   r = 8'h0D;
            8'h74:   r = 8'h09;
            default: r = b;
        endcase
        return r;
    endfunction

    assign c         = in_data.text_byte;
    assign eot       = in_data.end_of_text;
    assign in_stall  = q_stat.full;
    assign accept    = in_valid && !q_stat.full;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= '0;
            key_low_reg    <= '0;
            key_high_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_KEY_LENGTH: key_length_reg <= cfg_data[KEY_LEN_W-1:0];
                CFG_KEY_LOW:    key_low_reg    <= cfg_data;
                CFG_KEY_HIGH:   key_high_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        for (int j = 0; j < KEY_BYTES; j++)
        begin
            if (j < 8)
                key_arr[j] = key_low_reg[8*j +: 8];
            else
                key_arr[j] = key_high_reg[8*(j-8) +: 8];
        end
        win_new[0] = c;
        for (int i = 1; i < WIN_LEN; i++)
            win_new[i] = win_reg[i-1];
    end

    // clamp oversize keys to the window
    always_comb
    begin
        if (key_length_reg > KEY_LEN_W'(KEY_MAX))
            len_c = LEN_W'(KEY_MAX);
        else
            len_c = LEN_W'(key_length_reg);
    end

    // one fixed comparator row per candidate length, newest byte is the closing quote
    always_comb
    begin
        for (int l = 0; l <= KEY_MAX; l++)
        begin
            len_hit[l] = (win_new[0] == CH_QUOTE) && (win_new[l+1] == CH_QUOTE);
            for (int i = 1; i <= l; i++)
                len_hit[l] = len_hit[l] && (win_new[i] == key_arr[l-i]);
        end
    end

    assign seen_step = (seen_reg < SEEN_W'(WIN_LEN)) ? seen_reg + SEEN_W'(1) : seen_reg;
    assign key_hit   = len_hit[len_c]
                       && ({1'b0, seen_step} >= ((SEEN_W+1)'(len_c) + (SEEN_W+1)'(2)));
    assign skip_dec  = (skip_reg != '0) ? skip_reg - SKIP_W'(1) : skip_reg;

    // next state
    always_comb
    begin
        phase_step = phase_reg;
        skip_next  = skip_reg;
        case (phase_reg)
            PH_SEARCH:
                if (key_hit)
                    phase_step = PH_COLON;
            PH_COLON:
                if (c == CH_COLON)
                    phase_step = PH_QUOTE;
            PH_QUOTE:
                if (c == CH_QUOTE)
                    phase_step = PH_STRING;
            PH_STRING:
                if (c == CH_QUOTE)
                    phase_step = PH_DONE;
                else if (c == CH_BSLASH)
                    phase_step = PH_ESCAPE;
            PH_ESCAPE:
                if (c == CH_U)
                begin
                    phase_step = PH_SKIP;
                    skip_next  = UNICODE_DIGITS;
                end
                else
                    phase_step = PH_STRING;
            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == '0)
                    phase_step = PH_STRING;
            end
            default: ;
        endcase
        phase_next = phase_step;
        seen_next  = seen_step;
        // end of text drops all per-text state
        if (eot)
        begin
            phase_next = PH_SEARCH;
            skip_next  = '0;
            seen_next  = '0;
        end
    end

    // results of this byte
    always_comb
    begin
        push_data = '0;
        case (phase_reg)
            PH_STRING:
                if (c == CH_QUOTE)
                begin
                    push_data.first_valid       = 1'b1;
                    push_data.first.item_kind   = KIND_STATUS;
                    push_data.first.found       = 1'b1;
                    push_data.first.last_of_run = eot;
                end
                else if (c != CH_BSLASH)
                begin
                    push_data.first_valid      = 1'b1;
                    push_data.first.item_kind  = KIND_VALUE;
                    push_data.first.value_byte = c;
                end
            PH_ESCAPE:
            begin
                push_data.first_valid      = 1'b1;
                push_data.first.item_kind  = KIND_VALUE;
                push_data.first.value_byte = (c == CH_U) ? CH_QMARK : map_escape(c);
            end
            default: ;
        endcase
        if (eot && phase_step != PH_DONE)
        begin
            push_data.second_valid       = 1'b1;
            push_data.second.item_kind   = KIND_STATUS;
            push_data.second.last_of_run = 1'b1;
        end
    end

    assign push = accept && (push_data.first_valid || push_data.second_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEARCH;
            skip_reg  <= '0;
            seen_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            skip_reg  <= skip_next;
            seen_reg  <= seen_next;
        end
    end

    // window bytes beyond the fill count are never compared, so no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_reg[0] <= c;
            for (int i = 1; i < WIN_LEN - 1; i++)
                win_reg[i] <= win_reg[i-1];
        end
    end

endmodule

>>> hdl/jkse_queue.sv
// Short queue of classified words between front and back end.
module jkse_queue #(
    parameter int DEPTH = jkse_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  jkse_pkg::q_entry_t   push_data,
    input  logic                 pop,
    output jkse_pkg::q_entry_t   rd_data,
    output jkse_pkg::q_status_t  q_stat
);
    import jkse_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_entry_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    assign rd_data      = slot_reg[rd_ptr_reg];
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

>>> hdl/jkse_back.sv
// Back end: unpacks queued words into single result items behind an output register.
module jkse_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  jkse_pkg::q_status_t  q_stat,
    input  jkse_pkg::q_entry_t   rd_data,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output jkse_pkg::out_item_t  out_data
);
    import jkse_pkg::*;

    out_item_t out_reg, pend_reg;
    logic      out_valid_reg, pend_valid_reg;
    logic      out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign pop       = out_free && !pend_valid_reg && !q_stat.empty;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else if (pop)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= rd_data.first_valid && rd_data.second_valid;
            end
            else
                out_valid_reg <= 1'b0;
        end
    end

    // hold the trailing status while the leading item drains
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (pend_valid_reg)
                out_reg <= pend_reg;
            else if (pop)
            begin
                out_reg  <= rd_data.first_valid ? rd_data.first : rd_data.second;
                pend_reg <= rd_data.second;
            end
        end
    end

endmodule

>>> hdl/json_key_string_extractor_top.sv
// Top level of the JSON key string extractor.
// Usage:
//   Write the key through the cfg channel while idle: index 0 key length, index 1 key bytes
//   zero to seven, index 2 key bytes eight to fifteen; cfg_ready is always high.
//   Stream the text on the in channel, one byte per word, end_of_text on the final byte.
//   The out channel returns decoded string bytes (item_kind 0) and one status word per text
//   (item_kind 1, found set if the string closed, last_of_run on the final-byte status).
// Timing:
//   One text byte is taken every cycle while in_stall is low. A result passes a queue slot
//   and the output register before it appears on out. A byte that yields two results (a
//   value byte and the not-found status at end of text) holds the output register for both
//   in turn; the front-to-back queue (four words by default) absorbs this and in_stall rises
//   only when it fills. The front end does the window compare and phase update per byte taken.
// Reset:
//   rst_n clears the key registers, the phase and the queue; no result is pending after it.
// Stall:
//   While out_stall is high the output word holds; the queue fills, then in_stall rises
//   until the back end drains a word.
module json_key_string_extractor_top #(
    parameter int KEY_MAX     = jkse_pkg::KEY_MAX_DEFAULT,
    parameter int QUEUE_DEPTH = jkse_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  jkse_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output jkse_pkg::out_item_t             out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [jkse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jkse_pkg::CFG_DATA_W-1:0] cfg_data
);
    import jkse_pkg::*;

    q_status_t q_stat;
    q_entry_t  push_data;
    q_entry_t  rd_data;
    logic      push;
    logic      pop;
    logic      eot_open;
    logic      out_is_value;
    logic      value_flags;

    jkse_front #(
        .KEY_MAX (KEY_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    jkse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .rd_data   (rd_data),
        .q_stat    (q_stat)
    );

    jkse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .rd_data   (rd_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // final byte of a text whose string has not closed yet
    assign eot_open     = in_valid && !in_stall && in_data.end_of_text
                          && (u_front.phase_reg != PH_DONE);
    assign out_is_value = out_valid && (out_data.item_kind == KIND_VALUE);
    assign value_flags  = out_data.found || out_data.last_of_run;

`include "json_key_string_extractor_top_assert.svh"

    // every open final byte leaves a status word in the queue
    `JKSE_ASSERT_NOW(a_eot_pushes, eot_open, push, "end of text without a queued status")
    // no word is written into a full queue
    `JKSE_ASSERT_NOW(a_no_overflow, push, !q_stat.full, "push into full queue")
    // a popped word shows up on the output register next cycle
    `JKSE_ASSERT_NEXT(a_pop_shows, pop, out_valid, "popped word not presented")
    // value bytes carry no status flags
    `JKSE_ASSERT_NOW(a_value_clean, out_is_value, !value_flags, "status flags on a value byte")

endmodule
